@@ rtl/core/rbr_pkg.sv @@
package rbr_pkg;

	localparam int unsigned COORD_W    = 10;
	localparam int unsigned SIZE_W     = 11;
	localparam int unsigned COUNT_W    = 21;
	localparam int unsigned OFFS_W     = 20;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	typedef logic [COORD_W-1:0]    coord_t;
	typedef logic [SIZE_W-1:0]     size_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [OFFS_W-1:0]     offs_t;
	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_PIXEL = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_WINDOW = 1'b0,
		KIND_PIXEL  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	localparam cfg_idx_t CFG_ROTATION     = 2'd0;
	localparam cfg_idx_t CFG_PANEL_WIDTH  = 2'd1;
	localparam cfg_idx_t CFG_PANEL_HEIGHT = 2'd2;

	localparam rot_t  RST_ROTATION   = ROT_90;
	localparam size_t RST_PANEL_SIZE = 11'd1024;

	typedef struct packed {
		rot_t  rotation;
		size_t panel_width;
		size_t panel_height;
	} regs_t;

	typedef struct packed {
		logic   opcode;
		coord_t first_col;
		coord_t first_row;
		coord_t last_col;
		coord_t last_row;
		pix_t   pixel_in;
	} req_t;

	typedef struct packed {
		logic   kind;
		coord_t win_x0;
		coord_t win_y0;
		coord_t win_x1;
		coord_t win_y1;
		count_t pixel_count;
		offs_t  source_offset;
		offs_t  dest_offset;
		pix_t   pixel_out;
		logic   last;
	} rsp_t;

	typedef struct packed {
		kind_t  kind;
		coord_t sc;
		coord_t sr;
		coord_t ec;
		coord_t er;
		size_t  mul_a;
		size_t  mul_b;
		coord_t add_c;
		coord_t src_y;
		coord_t src_x;
		size_t  lw;
		pix_t   pixel;
		logic   last;
	} s1_t;

endpackage

@@ rtl/core/rbr_if.sv @@
interface rbr_req_if;
	import rbr_pkg::*;
	logic   valid;
	logic   ready;
	logic   opcode;
	coord_t first_col;
	coord_t first_row;
	coord_t last_col;
	coord_t last_row;
	pix_t   pixel_in;

	modport source (
		output valid, opcode, first_col, first_row, last_col, last_row, pixel_in,
		input  ready
	);
	modport sink (
		input  valid, opcode, first_col, first_row, last_col, last_row, pixel_in,
		output ready
	);
endinterface

interface rbr_rsp_if;
	import rbr_pkg::*;
	logic   valid;
	logic   ready;
	logic   kind;
	coord_t win_x0;
	coord_t win_y0;
	coord_t win_x1;
	coord_t win_y1;
	count_t pixel_count;
	offs_t  source_offset;
	offs_t  dest_offset;
	pix_t   pixel_out;
	logic   last;

	modport source (
		output valid, kind, win_x0, win_y0, win_x1, win_y1, pixel_count,
		       source_offset, dest_offset, pixel_out, last,
		input  ready
	);
	modport sink (
		input  valid, kind, win_x0, win_y0, win_x1, win_y1, pixel_count,
		       source_offset, dest_offset, pixel_out, last,
		output ready
	);
endinterface

interface rbr_cfg_if;
	import rbr_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

@@ rtl/core/rbr_walk.sv @@
module rbr_walk #(
	parameter int unsigned COORD_LIMIT = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  rbr_pkg::req_t req,
	input  rbr_pkg::regs_t regs,
	input  logic          s1_adv,
	output logic          s1_valid,
	output rbr_pkg::s1_t  s1
);
	import rbr_pkg::*;

	localparam coord_t CLAMP_MAX = COORD_W'(COORD_LIMIT - 1);

	coord_t start_col_q, start_row_q, end_col_q, end_row_q, cur_col_q, cur_row_q;
	coord_t start_col_d, start_row_d, end_col_d, end_row_d, cur_col_d, cur_row_d;
	coord_t c0, r0, c1, r1, c1_raw, r1_raw;
	coord_t new_sc, new_sr, new_ec, new_er;
	size_t  new_w, new_h, w, h;
	coord_t rx, ry;
	size_t  rx_rev, ry_rev;
	logic   is_last;
	logic   s1_valid_q;
	s1_t    s1_d, s1_s1;

	function automatic coord_t clamp(coord_t v);
		clamp = (32'(v) >= COORD_LIMIT) ? CLAMP_MAX : v;
	endfunction

	always_comb begin
		c0     = clamp(req.first_col);
		r0     = clamp(req.first_row);
		c1_raw = clamp(req.last_col);
		r1_raw = clamp(req.last_row);
		c1     = (c1_raw < c0) ? c0 : c1_raw;
		r1     = (r1_raw < r0) ? r0 : r1_raw;
		new_sc = {c0[COORD_W-1:1], 1'b0};
		new_sr = {r0[COORD_W-1:1], 1'b0};
		new_ec = c1 | COORD_W'(1);
		new_er = r1 | COORD_W'(1);
		new_w  = {1'b0, new_ec} - {1'b0, new_sc} + SIZE_W'(1);
		new_h  = {1'b0, new_er} - {1'b0, new_sr} + SIZE_W'(1);

		w       = {1'b0, end_col_q} - {1'b0, start_col_q} + SIZE_W'(1);
		h       = {1'b0, end_row_q} - {1'b0, start_row_q} + SIZE_W'(1);
		rx      = cur_col_q - start_col_q;
		ry      = cur_row_q - start_row_q;
		rx_rev  = w - SIZE_W'(1) - {1'b0, rx};
		ry_rev  = h - SIZE_W'(1) - {1'b0, ry};
		is_last = (cur_col_q == end_col_q) && (cur_row_q == end_row_q);

		s1_d       = '0;
		s1_d.sc    = new_sc;
		s1_d.sr    = new_sr;
		s1_d.ec    = new_ec;
		s1_d.er    = new_er;
		s1_d.src_y = cur_row_q;
		s1_d.src_x = cur_col_q;
		s1_d.lw    = (regs.rotation == ROT_0 || regs.rotation == ROT_180) ?
		             regs.panel_width : regs.panel_height;
		s1_d.pixel = {req.pixel_in[7:0], req.pixel_in[15:8]};
		s1_d.last  = is_last;

		start_col_d = start_col_q;
		start_row_d = start_row_q;
		end_col_d   = end_col_q;
		end_row_d   = end_row_q;
		cur_col_d   = cur_col_q;
		cur_row_d   = cur_row_q;

		if (req.opcode == OP_START) begin
			s1_d.kind   = KIND_WINDOW;
			s1_d.mul_a  = new_w;
			s1_d.mul_b  = new_h;
			s1_d.add_c  = '0;
			start_col_d = new_sc;
			start_row_d = new_sr;
			end_col_d   = new_ec;
			end_row_d   = new_er;
			cur_col_d   = new_sc;
			cur_row_d   = new_sr;
		end else begin
			s1_d.kind = KIND_PIXEL;
			case (regs.rotation)
				ROT_0: begin
					s1_d.mul_a = {1'b0, ry};
					s1_d.mul_b = w;
					s1_d.add_c = rx;
				end
				ROT_180: begin
					s1_d.mul_a = ry_rev;
					s1_d.mul_b = w;
					s1_d.add_c = rx_rev[COORD_W-1:0];
				end
				ROT_90: begin
					s1_d.mul_a = rx_rev;
					s1_d.mul_b = h;
					s1_d.add_c = ry;
				end
				default: begin
					s1_d.mul_a = {1'b0, rx};
					s1_d.mul_b = h;
					s1_d.add_c = ry_rev[COORD_W-1:0];
				end
			endcase
			if (is_last) begin
				cur_col_d = start_col_q;
				cur_row_d = start_row_q;
			end else if (cur_col_q >= end_col_q) begin
				cur_col_d = start_col_q;
				cur_row_d = cur_row_q + COORD_W'(1);
			end else begin
				cur_col_d = cur_col_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q <= '0;
			start_row_q <= '0;
			end_col_q   <= '0;
			end_row_q   <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				start_col_q <= start_col_d;
				start_row_q <= start_row_d;
				end_col_q   <= end_col_d;
				end_row_q   <= end_row_d;
				cur_col_q   <= cur_col_d;
				cur_row_q   <= cur_row_d;
				s1_valid_q  <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1       = s1_s1;

endmodule

@@ rtl/core/rbr_result.sv @@
module rbr_result (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s1_adv,
	input  rbr_pkg::s1_t   s1,
	input  rbr_pkg::regs_t regs,
	input  logic           take,
	output logic           rsp_valid,
	output rbr_pkg::rsp_t  rsp
);
	import rbr_pkg::*;

	logic [2*SIZE_W-1:0] dst_sum;
	logic [2*SIZE_W-1:0] src_sum;
	coord_t pw, ph, x0, y0, x1, y1;
	rsp_t   rsp_d, rsp_q;
	logic   rsp_valid_q;

	always_comb begin
		dst_sum = s1.mul_a * s1.mul_b + (2*SIZE_W)'(s1.add_c);
		src_sum = s1.src_y * s1.lw + (2*SIZE_W)'(s1.src_x);
		pw      = regs.panel_width[COORD_W-1:0];
		ph      = regs.panel_height[COORD_W-1:0];

		case (regs.rotation)
			ROT_0: begin
				x0 = s1.sc;
				y0 = s1.sr;
				x1 = s1.ec;
				y1 = s1.er;
			end
			ROT_180: begin
				x0 = pw - COORD_W'(1) - s1.ec;
				y0 = ph - COORD_W'(1) - s1.er;
				x1 = pw - COORD_W'(1) - s1.sc;
				y1 = ph - COORD_W'(1) - s1.sr;
			end
			ROT_90: begin
				x0 = s1.sr;
				y0 = ph - COORD_W'(1) - s1.ec;
				x1 = s1.er;
				y1 = ph - COORD_W'(1) - s1.sc;
			end
			default: begin
				x0 = pw - COORD_W'(1) - s1.er;
				y0 = s1.sc;
				x1 = pw - COORD_W'(1) - s1.sr;
				y1 = s1.ec;
			end
		endcase

		rsp_d      = '0;
		rsp_d.kind = s1.kind;
		if (s1.kind == KIND_WINDOW) begin
			rsp_d.win_x0      = x0;
			rsp_d.win_y0      = y0;
			rsp_d.win_x1      = x1;
			rsp_d.win_y1      = y1;
			rsp_d.pixel_count = dst_sum[COUNT_W-1:0];
		end else begin
			rsp_d.source_offset = src_sum[OFFS_W-1:0];
			rsp_d.dest_offset   = dst_sum[OFFS_W-1:0];
			rsp_d.pixel_out     = s1.pixel;
			rsp_d.last          = s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/rotate_blit_rgb565_region.sv @@
// channel | dir | handshake   | payload
// req     | in  | valid/ready | opcode, first_col, first_row, last_col, last_row, pixel_in
// rsp     | out | valid/ready | kind, win_x0..win_y1, pixel_count, source_offset,
//         |     |             | dest_offset, pixel_out, last
// cfg     | in  | valid/ready | index, data (rotation, panel_width, panel_height)
//
// One item per cycle unless rsp stalls; an item taken on req passes the operand register
// and then the result register before its result shows on rsp. The walk counters advance
// at accept, with one multiply-add per result field between the two registers.
// req.ready drops only while both registers hold items and rsp is stalled.
// Reset: rotation 90, panel 1024 x 1024, region a single pixel at the origin.
module rotate_blit_rgb565_region #(
	parameter int unsigned COORD_LIMIT = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	rbr_req_if.sink   req,
	rbr_rsp_if.source rsp,
	rbr_cfg_if.sink   cfg
);
	import rbr_pkg::*;

	regs_t regs_q;
	req_t  req_item;
	rsp_t  rsp_item;
	s1_t   s1;
	logic  s1_valid, s1_adv, take, accept, rsp_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{rotation: RST_ROTATION, panel_width: RST_PANEL_SIZE,
			            panel_height: RST_PANEL_SIZE};
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ROTATION:     regs_q.rotation     <= rot_t'(cfg.data[1:0]);
				CFG_PANEL_WIDTH:  regs_q.panel_width  <= cfg.data;
				CFG_PANEL_HEIGHT: regs_q.panel_height <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req_item = '{opcode: req.opcode, first_col: req.first_col,
	                    first_row: req.first_row, last_col: req.last_col,
	                    last_row: req.last_row, pixel_in: req.pixel_in};

	assign take      = !rsp_valid || rsp.ready;
	assign s1_adv    = s1_valid && take;
	assign req.ready = !s1_valid || take;
	assign accept    = req.valid && req.ready;

	rbr_walk #(
		.COORD_LIMIT(COORD_LIMIT)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req_item),
		.regs    (regs_q),
		.s1_adv  (s1_adv),
		.s1_valid(s1_valid),
		.s1      (s1)
	);

	rbr_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_adv   (s1_adv),
		.s1       (s1),
		.regs     (regs_q),
		.take     (take),
		.rsp_valid(rsp_valid),
		.rsp      (rsp_item)
	);

	assign rsp.valid         = rsp_valid;
	assign rsp.kind          = rsp_item.kind;
	assign rsp.win_x0        = rsp_item.win_x0;
	assign rsp.win_y0        = rsp_item.win_y0;
	assign rsp.win_x1        = rsp_item.win_x1;
	assign rsp.win_y1        = rsp_item.win_y1;
	assign rsp.pixel_count   = rsp_item.pixel_count;
	assign rsp.source_offset = rsp_item.source_offset;
	assign rsp.dest_offset   = rsp_item.dest_offset;
	assign rsp.pixel_out     = rsp_item.pixel_out;
	assign rsp.last          = rsp_item.last;

endmodule

@@ rtl/core/rbr_checker.sv @@
module rbr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                rsp_kind,
	input rbr_pkg::count_t     rsp_pixel_count,
	input rbr_pkg::offs_t      rsp_dest_offset,
	input rbr_pkg::pix_t       rsp_pixel_out,
	input logic                rsp_last
);
	import rbr_pkg::*;

	logic       req_acc, rsp_acc;
	logic [2:0] inflight_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(req_acc) - 3'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
		$stable(rsp_pixel_count) && $stable(rsp_dest_offset) &&
		$stable(rsp_pixel_out) && $stable(rsp_last))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != 3'd0)
		else $error("result without an item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("more than two items in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && inflight_q == 3'd0 |-> ##2 rsp_valid)
		else $error("result of an item into an empty pipe is late");

endmodule

bind rotate_blit_rgb565_region rbr_checker u_rbr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_pixel_count(rsp.pixel_count),
	.rsp_dest_offset(rsp.dest_offset),
	.rsp_pixel_out  (rsp.pixel_out),
	.rsp_last       (rsp.last)
);

@@ dv/rotate_blit_rgb565_region_tb.sv @@
import rbr_pkg::*;

class rotblit_board;
	rot_t   rot;
	size_t  pw;
	size_t  ph;
	coord_t sc, sr, ec, er, cc, cr;
	rsp_t   due_results[$];
	int     errors;

	function new();
		rot = RST_ROTATION;
		pw = RST_PANEL_SIZE;
		ph = RST_PANEL_SIZE;
		sc = '0; sr = '0; ec = '0; er = '0; cc = '0; cr = '0;
		errors = 0;
	endfunction

	function void write_reg(cfg_idx_t idx, cfg_data_t d);
		case (idx)
			CFG_ROTATION:     rot = rot_t'(d[1:0]);
			CFG_PANEL_WIDTH:  pw = d;
			CFG_PANEL_HEIGHT: ph = d;
			default: ;
		endcase
	endfunction

	function void take_item(req_t it);
		rsp_t r;
		int unsigned w, h, c0, r0, c1, r1, x0, y0, x1, y1, rx, ry, lw, dst;
		logic fin;
		r = '0;
		w = ec - sc + 1;
		h = er - sr + 1;
		if (it.opcode == OP_START) begin
			c0 = it.first_col;
			r0 = it.first_row;
			c1 = it.last_col;
			r1 = it.last_row;
			if (c1 < c0) c1 = c0;
			if (r1 < r0) r1 = r0;
			sc = coord_t'(c0 & ~32'd1);
			sr = coord_t'(r0 & ~32'd1);
			ec = coord_t'(c1 | 32'd1);
			er = coord_t'(r1 | 32'd1);
			cc = sc;
			cr = sr;
			w = ec - sc + 1;
			h = er - sr + 1;
			case (rot)
				ROT_0: begin
					x0 = sc; y0 = sr; x1 = ec; y1 = er;
				end
				ROT_180: begin
					x0 = pw - 1 - ec; y0 = ph - 1 - er;
					x1 = pw - 1 - sc; y1 = ph - 1 - sr;
				end
				ROT_90: begin
					x0 = sr; y0 = ph - 1 - ec;
					x1 = er; y1 = ph - 1 - sc;
				end
				default: begin
					x0 = pw - 1 - er; y0 = sc;
					x1 = pw - 1 - sr; y1 = ec;
				end
			endcase
			r.kind = KIND_WINDOW;
			r.win_x0 = coord_t'(x0);
			r.win_y0 = coord_t'(y0);
			r.win_x1 = coord_t'(x1);
			r.win_y1 = coord_t'(y1);
			r.pixel_count = count_t'(w * h);
		end else begin
			rx = cc - sc;
			ry = cr - sr;
			lw = (rot == ROT_0 || rot == ROT_180) ? pw : ph;
			fin = (cc == ec) && (cr == er);
			case (rot)
				ROT_0:   dst = ry * w + rx;
				ROT_180: dst = (h - 1 - ry) * w + (w - 1 - rx);
				ROT_90:  dst = (w - 1 - rx) * h + ry;
				default: dst = rx * h + (h - 1 - ry);
			endcase
			r.kind = KIND_PIXEL;
			r.source_offset = offs_t'(cr * lw + cc);
			r.dest_offset = offs_t'(dst);
			r.pixel_out = {it.pixel_in[7:0], it.pixel_in[15:8]};
			r.last = fin;
			if (fin) begin
				cc = sc;
				cr = sr;
			end else if (cc >= ec) begin
				cc = sc;
				cr = cr + 1'b1;
			end else begin
				cc = cc + 1'b1;
			end
		end
		due_results.push_back(r);
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 200)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task cmp(string nm, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0h, expected %0h", nm, got, want));
	endtask

	task match_result(rsp_t got);
		rsp_t want;
		if (due_results.size() == 0) begin
			report("result with no item pending");
			return;
		end
		want = due_results.pop_front();
		cmp("kind", got.kind, want.kind);
		cmp("win_x0", got.win_x0, want.win_x0);
		cmp("win_y0", got.win_y0, want.win_y0);
		cmp("win_x1", got.win_x1, want.win_x1);
		cmp("win_y1", got.win_y1, want.win_y1);
		cmp("pixel_count", got.pixel_count, want.pixel_count);
		cmp("source_offset", got.source_offset, want.source_offset);
		cmp("dest_offset", got.dest_offset, want.dest_offset);
		cmp("pixel_out", got.pixel_out, want.pixel_out);
		cmp("last", got.last, want.last);
	endtask
endclass

module rotate_blit_rgb565_region_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;

	rbr_req_if req_ch();
	rbr_rsp_if rsp_ch();
	rbr_cfg_if cfg_ch();

	rotate_blit_rgb565_region u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	rotblit_board sb = new();

	int unsigned sent = 0;
	int unsigned req_gap_max = 3;
	int unsigned rsp_gap_max = 3;
	bit          hold_rsp = 1'b0;
	req_t        seen_req;
	rsp_t        seen_rsp;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
			if (req_ch.valid && req_ch.ready) begin
				seen_req.opcode = req_ch.opcode;
				seen_req.first_col = req_ch.first_col;
				seen_req.first_row = req_ch.first_row;
				seen_req.last_col = req_ch.last_col;
				seen_req.last_row = req_ch.last_row;
				seen_req.pixel_in = req_ch.pixel_in;
				sb.take_item(seen_req);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_rsp.kind = rsp_ch.kind;
				seen_rsp.win_x0 = rsp_ch.win_x0;
				seen_rsp.win_y0 = rsp_ch.win_y0;
				seen_rsp.win_x1 = rsp_ch.win_x1;
				seen_rsp.win_y1 = rsp_ch.win_y1;
				seen_rsp.pixel_count = rsp_ch.pixel_count;
				seen_rsp.source_offset = rsp_ch.source_offset;
				seen_rsp.dest_offset = rsp_ch.dest_offset;
				seen_rsp.pixel_out = rsp_ch.pixel_out;
				seen_rsp.last = rsp_ch.last;
				sb.match_result(seen_rsp);
			end
		end
	end

	initial begin
		int unsigned n;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = hold_rsp ? 48 : $urandom_range(0, rsp_gap_max);
			hold_rsp = 1'b0;
			if (n != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	function automatic int unsigned pick_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? $urandom_range(1022, 1023) : $urandom_range(0, 1);
		return $urandom_range(0, 1023);
	endfunction

	task automatic push(opcode_t op, coord_t c0, coord_t r0, coord_t c1, coord_t r1, pix_t px);
		int unsigned gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.first_col <= c0;
		req_ch.first_row <= r0;
		req_ch.last_col <= c1;
		req_ch.last_row <= r1;
		req_ch.pixel_in <= px;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	task automatic start_region(int unsigned c0, int unsigned r0, int unsigned c1,
		int unsigned r1);
		push(OP_START, coord_t'(c0), coord_t'(r0), coord_t'(c1), coord_t'(r1), pix_t'($urandom));
	endtask

	task automatic send_pixels(int unsigned n);
		repeat (n)
			push(OP_PIXEL, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), pix_t'($urandom));
	endtask

	task automatic walk_region(bit partial);
		int unsigned c0, r0, c1, r1, n;
		c0 = pick_coord();
		r0 = pick_coord();
		c1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, c0) : c0 + $urandom_range(0, 5);
		r1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, r0) : r0 + $urandom_range(0, 5);
		if (c1 > 1023) c1 = 1023;
		if (r1 > 1023) r1 = 1023;
		start_region(c0, r0, c1, r1);
		n = ((((c1 < c0) ? c0 : c1) | 32'd1) - (c0 & ~32'd1) + 1)
			* ((((r1 < r0) ? r0 : r1) | 32'd1) - (r0 & ~32'd1) + 1);
		if (partial)
			n = $urandom_range(0, n - 1);
		send_pixels(n);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(rot_t r, size_t w, size_t h);
		cfg_idx_t  idx[3] = '{CFG_ROTATION, CFG_PANEL_WIDTH, CFG_PANEL_HEIGHT};
		cfg_data_t val[3];
		val[0] = cfg_data_t'(r);
		val[1] = w;
		val[2] = h;
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("rotate_blit_rgb565_region regression: fail");
		$finish;
	end

	initial begin
		int unsigned target, pick;
		rot_t        r;
		size_t       w, h;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_START;
		req_ch.first_col <= '0;
		req_ch.first_row <= '0;
		req_ch.last_col <= '0;
		req_ch.last_row <= '0;
		req_ch.pixel_in <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_ROTATION;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push(OP_PIXEL, '0, '0, '0, '0, 16'h0000);
		push(OP_PIXEL, '1, '1, '1, '1, 16'hFFFF);
		start_region(0, 0, 1023, 1023);
		push(OP_PIXEL, '0, '0, '0, '0, 16'h00FF);
		start_region(9, 7, 3, 2);
		push(OP_PIXEL, '0, '0, '0, '0, 16'hFF00);
		push(OP_PIXEL, '0, '0, '0, '0, 16'h1234);
		push(OP_PIXEL, '0, '0, '0, '0, 16'hA55A);
		push(OP_PIXEL, '0, '0, '0, '0, 16'h5AA5);
		push(OP_PIXEL, '0, '0, '0, '0, 16'h8001);
		start_region(1023, 1023, 1023, 1023);
		send_pixels(4);
		start_region(1023, 0, 0, 1023);
		send_pixels(1);
		start_region(0, 1, 1022, 1022);
		send_pixels(2);

		for (int p = 0; p < 9; p++) begin
			if (p > 0) begin
				case (p)
					1: begin r = ROT_0;   w = 11'd1024; h = 11'd1024; end
					2: begin r = ROT_180; w = 11'd2;    h = 11'd2;    end
					3: begin r = ROT_270; w = 11'd1024; h = 11'd2;    end
					4: begin r = ROT_90;  w = 11'd2;    h = 11'd1024; end
					default: begin
						r = rot_t'($urandom_range(0, 3));
						w = size_t'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 1024)
							: 2 * $urandom_range(1, 512));
						h = size_t'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 1024)
							: 2 * $urandom_range(1, 512));
					end
				endcase
				program_regs(r, w, h);
			end
			req_gap_max = (p % 3 == 1) ? 0 : 3;
			rsp_gap_max = (p % 4 == 2) ? 0 : 3;
			if (p == 1 || p == 7)
				hold_rsp = 1'b1;
			target = sent + 210;
			while (sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					walk_region(1'b0);
				end else if (pick < 80) begin
					walk_region(1'b1);
				end else if (pick < 88) begin
					start_region(pick_coord(), pick_coord(), pick_coord(), pick_coord());
					send_pixels($urandom_range(0, 3));
				end else if (pick < 94) begin
					send_pixels($urandom_range(1, 4));
				end else begin
					start_region($urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("rotate_blit_rgb565_region regression: pass");
		else
			$display("rotate_blit_rgb565_region regression: fail");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/rbr_pkg.sv
rtl/core/rbr_if.sv
rtl/core/rbr_walk.sv
rtl/core/rbr_result.sv
rtl/core/rotate_blit_rgb565_region.sv
rtl/core/rbr_checker.sv
dv/rotate_blit_rgb565_region_tb.sv
